@@ rtl/pagerank_pull_accumulate_top_macros.svh @@
// Assertion macros for the PageRank pull accumulator.
// Used by the top level only; needs nothing else.
`ifndef PAGERANK_PULL_ACCUMULATE_TOP_MACROS_SVH
`define PAGERANK_PULL_ACCUMULATE_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PPRK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PPRK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pprk_pkg.sv @@
// Shared types and constants of the PageRank pull accumulator.
// Used by pprk_div and pagerank_pull_accumulate_top; depends on nothing.
package pprk_pkg;

    localparam int VERTEX_DEPTH = 65536;
    localparam int INDEX_W      = 16;
    localparam int INDEX_SPAN   = 1 << INDEX_W;
    // Vertex indexes are 16 bits, so no more entries than that can be addressed.
    localparam int MEM_DEPTH    = (VERTEX_DEPTH > INDEX_SPAN) ? INDEX_SPAN : VERTEX_DEPTH;
    localparam int ADDR_W       = $clog2(MEM_DEPTH);

    localparam int RANK_W  = 32;
    localparam int DEG_W   = 24;
    localparam int SUM_W   = 48;
    localparam int SEQ_W   = 16;
    localparam int FRAC_W  = 31;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;

    localparam logic REG_TELEPORT = 1'b0;
    localparam logic REG_DAMPING  = 1'b1;

    localparam logic [31:0] DAMPING_RESET = 32'd1825361101;

    typedef struct packed {
        logic [1:0]         op;
        logic [INDEX_W-1:0] vertex_index;
        logic [RANK_W-1:0]  rank_value;
        logic [DEG_W-1:0]   out_degree;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [RANK_W-1:0] new_rank;
        logic [SEQ_W-1:0]  dest_seq;
        logic              saturated;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [RANK_W-1:0] dividend;
        logic [DEG_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [RANK_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/pprk_div.sv @@
// Restoring divider, one quotient bit per cycle: rank word over degree.
// Depends on pprk_pkg for widths and the request and response structs.
module pprk_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pprk_pkg::t_div_req i_req,
    output pprk_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(pprk_pkg::RANK_W);

    logic                        r_running;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [pprk_pkg::RANK_W-1:0] r_quo;
    logic [pprk_pkg::DEG_W-1:0]  r_rem;
    logic [pprk_pkg::DEG_W-1:0]  r_dvs;

    logic [pprk_pkg::DEG_W:0]    trial;
    logic                        ge;
    logic [pprk_pkg::DEG_W:0]    diff;

    always_comb begin
        trial = {r_rem, r_quo[pprk_pkg::RANK_W-1]};
        ge    = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_done    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_running <= 1'b1;
                r_cnt     <= '0;
                r_quo     <= i_req.dividend;
                r_rem     <= '0;
                r_dvs     <= i_req.divisor;
            end else if (r_running) begin
                // The partial remainder always stays below the divisor.
                r_rem <= ge ? diff[pprk_pkg::DEG_W-1:0] : trial[pprk_pkg::DEG_W-1:0];
                r_quo <= {r_quo[pprk_pkg::RANK_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(pprk_pkg::RANK_W - 1)) begin
                    r_running <= 1'b0;
                    r_done    <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_running;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ rtl/pagerank_pull_accumulate_top.sv @@
// One pull-style PageRank iteration: vertex rank and degree tables, edge accumulator, scaling.
// Depends on pprk_pkg, pprk_div and pagerank_pull_accumulate_top_macros.svh.
//
// A word is taken when start is high and busy is low. Vertex writes, empty-destination
// words and unknown ops leave busy low, so another word can follow at once. An edge word
// goes through a table read, 32 steps of the bit-serial divider and the accumulate; an edge
// marked last goes on to two partial products on one shared multiplier, the scale
// add and the clip, after which the result shows. Each result is on o_result for a single
// cycle with o_res_strobe high and must be taken then, as nothing holds it. The tables need
// no clearing after reset; an entry must be written before an edge reads it.
`include "pagerank_pull_accumulate_top_macros.svh"

module pagerank_pull_accumulate_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pprk_pkg::t_item       i_item,
    output logic                  o_res_strobe,
    output pprk_pkg::t_result     o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int PHI_W   = pprk_pkg::RANK_W + pprk_pkg::DEG_W;
    localparam int PROD_W  = pprk_pkg::RANK_W + pprk_pkg::SUM_W;
    localparam int SCALE_W = PROD_W - pprk_pkg::FRAC_W;
    localparam int HALF_W  = pprk_pkg::SUM_W / 2;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DIV, S_MUL_HI, S_MUL_LO, S_SCALE, S_EMIT
    } t_state;

    // Vertex tables.
    logic [pprk_pkg::RANK_W-1:0] rank_mem [pprk_pkg::MEM_DEPTH];
    logic [pprk_pkg::DEG_W-1:0]  deg_mem  [pprk_pkg::MEM_DEPTH];

    t_state                      r_state, n_state;
    logic [pprk_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [pprk_pkg::SEQ_W-1:0]  r_dest_cnt, n_dest_cnt;
    logic                        r_last, n_last;
    logic                        r_in_range, n_in_range;
    logic [PHI_W-1:0]            r_p_hi, n_p_hi;
    logic [PHI_W-1:0]            r_p_lo, n_p_lo;
    logic [SCALE_W-1:0]          r_scaled, n_scaled;
    logic                        r_res_strobe, n_res_strobe;
    pprk_pkg::t_result           r_result, n_result;
    logic [31:0]                 r_teleport;
    logic [31:0]                 r_damping;
    logic [pprk_pkg::RANK_W-1:0] r_rank_rd;
    logic [pprk_pkg::DEG_W-1:0]  r_deg_rd;

    logic                        accept;
    logic                        cfg_wr;
    logic                        idx_ok;
    logic [pprk_pkg::ADDR_W-1:0] addr;
    logic [pprk_pkg::DEG_W-1:0]  deg_store;

    pprk_pkg::t_div_req          div_req;
    pprk_pkg::t_div_rsp          div_rsp;

    logic [HALF_W-1:0]           mul_b;
    logic [PHI_W-1:0]            mul_p;
    logic [PROD_W-1:0]           prod_full;
    logic [SCALE_W:0]            emit_val;
    logic [pprk_pkg::SUM_W:0]    sum_add;

    assign accept    = start && !busy;
    assign busy      = r_state != S_IDLE;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign idx_ok    = {1'b0, i_item.vertex_index} < 17'(pprk_pkg::MEM_DEPTH);
    assign addr      = i_item.vertex_index[pprk_pkg::ADDR_W-1:0];
    assign deg_store = (i_item.out_degree == '0) ? pprk_pkg::DEG_W'(1) : i_item.out_degree;

    assign prdata = (paddr[2] == pprk_pkg::REG_DAMPING) ? r_damping : r_teleport;

    // Tables: one write port for vertex words, one registered read for edge words.
    always_ff @(posedge i_clk) begin
        if (accept && i_item.op == pprk_pkg::OP_WRITE && idx_ok) begin
            rank_mem[addr] <= i_item.rank_value;
            deg_mem[addr]  <= deg_store;
        end
        if (accept && i_item.op == pprk_pkg::OP_EDGE) begin
            r_rank_rd <= rank_mem[addr];
            r_deg_rd  <= deg_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_teleport <= '0;
            r_damping  <= pprk_pkg::DAMPING_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == pprk_pkg::REG_DAMPING) begin
                r_damping <= pwdata;
            end else begin
                r_teleport <= pwdata;
            end
        end
    end

    assign div_req.start    = r_state == S_READ && r_in_range;
    assign div_req.dividend = r_rank_rd;
    assign div_req.divisor  = (r_deg_rd == '0) ? pprk_pkg::DEG_W'(1) : r_deg_rd;

    pprk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // One multiplier serves both halves of the 48-bit sum.
    always_comb begin
        mul_b     = (r_state == S_MUL_HI) ? r_sum[pprk_pkg::SUM_W-1:HALF_W]
                                          : r_sum[HALF_W-1:0];
        mul_p     = PHI_W'(r_damping) * PHI_W'(mul_b);
        prod_full = {r_p_hi, {HALF_W{1'b0}}} + PROD_W'(r_p_lo);
        emit_val  = {1'b0, r_scaled} + (SCALE_W + 1)'(r_teleport);
        sum_add   = {1'b0, r_sum} + (pprk_pkg::SUM_W + 1)'(div_rsp.quotient);
    end

    always_comb begin
        n_state      = r_state;
        n_sum        = r_sum;
        n_dest_cnt   = r_dest_cnt;
        n_last       = r_last;
        n_in_range   = r_in_range;
        n_p_hi       = r_p_hi;
        n_p_lo       = r_p_lo;
        n_scaled     = r_scaled;
        n_res_strobe = 1'b0;
        n_result     = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.op)
                        pprk_pkg::OP_EDGE: begin
                            n_last     = i_item.last;
                            n_in_range = idx_ok;
                            n_state    = S_READ;
                        end
                        pprk_pkg::OP_EMPTY: begin
                            n_result.new_rank  = r_teleport;
                            n_result.dest_seq  = r_dest_cnt;
                            n_result.saturated = 1'b0;
                            n_res_strobe       = 1'b1;
                            n_dest_cnt         = r_dest_cnt + 1'b1;
                            n_sum              = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                // An edge from beyond the table adds nothing.
                if (r_in_range) begin
                    n_state = S_DIV;
                end else begin
                    n_state = r_last ? S_MUL_HI : S_IDLE;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_sum   = sum_add[pprk_pkg::SUM_W] ? '1 : sum_add[pprk_pkg::SUM_W-1:0];
                    n_state = r_last ? S_MUL_HI : S_IDLE;
                end
            end
            S_MUL_HI: begin
                n_p_hi  = mul_p;
                n_state = S_MUL_LO;
            end
            S_MUL_LO: begin
                n_p_lo  = mul_p;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_scaled = prod_full[PROD_W-1:pprk_pkg::FRAC_W];
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                n_result.saturated = |emit_val[SCALE_W:pprk_pkg::RANK_W];
                n_result.new_rank  = n_result.saturated ? '1
                                                        : emit_val[pprk_pkg::RANK_W-1:0];
                n_result.dest_seq  = r_dest_cnt;
                n_res_strobe       = 1'b1;
                n_dest_cnt         = r_dest_cnt + 1'b1;
                n_sum              = '0;
                n_state            = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sum        <= '0;
            r_dest_cnt   <= '0;
            r_res_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sum        <= n_sum;
            r_dest_cnt   <= n_dest_cnt;
            r_res_strobe <= n_res_strobe;
        end
        r_last     <= n_last;
        r_in_range <= n_in_range;
        r_p_hi     <= n_p_hi;
        r_p_lo     <= n_p_lo;
        r_scaled   <= n_scaled;
        r_result   <= n_result;
    end

    assign o_res_strobe = r_res_strobe;
    assign o_result     = r_result;

    `PPRK_ASSERT_NOW(a_seq_advances, i_clk, i_rst_n, o_res_strobe, r_dest_cnt == o_result.dest_seq + 1'b1, "sequence counter did not advance with a result")
    `PPRK_ASSERT_NOW(a_div_start_idle, i_clk, i_rst_n, div_req.start, !div_rsp.busy, "divider started while still running")
    `PPRK_ASSERT_NOW(a_div_in_state, i_clk, i_rst_n, div_rsp.busy, r_state == S_DIV, "divider running outside the divide state")
    `PPRK_ASSERT_NOW(a_sat_clipped, i_clk, i_rst_n, o_res_strobe && o_result.saturated, o_result.new_rank == '1, "saturated result not clipped to the maximum")

endmodule

@@ tb/tb.sv @@
// Self-checking bench for pagerank_pull_accumulate_top: directed and random command words,
// with a rank predictor held in a small scoreboard class. Depends on pprk_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The package names the three live ops only; the fourth is a word the block ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 48;

    class rank_update_board;
        logic [31:0]       teleport;
        logic [31:0]       damping;
        logic [31:0]       rank_mem [0:65535];
        logic [23:0]       degree_mem [0:65535];
        bit                loaded [0:65535];
        logic [15:0]       loaded_ids[$];
        logic [47:0]       rank_sum;
        logic [15:0]       next_seq;
        pprk_pkg::t_result pending_ranks[$];
        int                errors;

        function new();
            teleport = '0;
            damping  = pprk_pkg::DAMPING_RESET;
            rank_sum = '0;
            next_seq = '0;
            errors   = 0;
        endfunction

        function void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == pprk_pkg::REG_TELEPORT) begin
                teleport = value;
            end else begin
                damping = value;
            end
        endfunction

        // Every result clips at all ones, carries the running sequence number and clears the sum.
        function void push_rank(logic [49:0] value);
            pprk_pkg::t_result r;
            r.saturated = (value > 50'h0_FFFF_FFFF);
            r.new_rank  = r.saturated ? 32'hFFFF_FFFF : value[31:0];
            r.dest_seq  = next_seq;
            pending_ranks.push_back(r);
            next_seq++;
            rank_sum = '0;
        endfunction

        function void note_word(pprk_pkg::t_item w);
            logic [31:0] share;
            logic [48:0] grown;
            logic [79:0] product;
            case (w.op)
                pprk_pkg::OP_WRITE: begin
                    rank_mem[w.vertex_index]   = w.rank_value;
                    degree_mem[w.vertex_index] = (w.out_degree == '0) ? 24'd1 : w.out_degree;
                    if (!loaded[w.vertex_index]) begin
                        loaded[w.vertex_index] = 1'b1;
                        loaded_ids.push_back(w.vertex_index);
                    end
                end
                pprk_pkg::OP_EDGE: begin
                    share = '0;
                    if (loaded[w.vertex_index]) begin
                        share = rank_mem[w.vertex_index] / degree_mem[w.vertex_index];
                    end
                    grown    = {1'b0, rank_sum} + {17'd0, share};
                    rank_sum = grown[48] ? 48'hFFFF_FFFF_FFFF : grown[47:0];
                    if (w.last) begin
                        product = {48'd0, damping} * {32'd0, rank_sum};
                        push_rank({1'b0, product[79:31]} + {18'd0, teleport});
                    end
                end
                pprk_pkg::OP_EMPTY: begin
                    push_rank({18'd0, teleport});
                end
                default: ;
            endcase
        endfunction

        function void check_rank(pprk_pkg::t_result got);
            pprk_pkg::t_result want;
            if (pending_ranks.size() == 0) begin
                report_mismatch("unexpected result word, new_rank", 32'h0, got.new_rank);
                return;
            end
            want = pending_ranks.pop_front();
            if (got.new_rank !== want.new_rank) begin
                report_mismatch("new_rank", want.new_rank, got.new_rank);
            end
            if (got.dest_seq !== want.dest_seq) begin
                report_mismatch("dest_seq", {16'd0, want.dest_seq}, {16'd0, got.dest_seq});
            end
            if (got.saturated !== want.saturated) begin
                report_mismatch("saturated", {31'd0, want.saturated}, {31'd0, got.saturated});
            end
        endfunction
    endclass

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    pprk_pkg::t_item   item_w  = '0;
    logic              o_res_strobe;
    pprk_pkg::t_result o_result;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [2:0]        paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    bit               gaps_on = 1'b1;
    rank_update_board board;

    pagerank_pull_accumulate_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (item_w),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 i_clk = ~i_clk;

    // Results cannot be held off, so each strobed word is checked at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            board.check_rank(o_result);
        end
    end

    function automatic pprk_pkg::t_item word(logic [1:0] op, logic [15:0] idx,
                                             logic [31:0] rank, logic [23:0] deg,
                                             logic last);
        pprk_pkg::t_item w;
        w.op           = op;
        w.vertex_index = idx;
        w.rank_value   = rank;
        w.out_degree   = deg;
        w.last         = last;
        return w;
    endfunction

    function automatic pprk_pkg::t_item random_item();
        pprk_pkg::t_item w;
        logic [31:0]     a;
        logic [31:0]     b;
        logic [31:0]     c;
        a = $urandom;
        b = $urandom;
        c = $urandom;
        w.op           = a[1:0];
        w.vertex_index = a[17:2];
        w.last         = a[18];
        w.rank_value   = b;
        w.out_degree   = c[23:0];
        return w;
    endfunction

    // Half the ranks are shifted down so that many sums stay clear of the clip.
    function automatic logic [31:0] rand_rank();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(1) == 0) begin
            r = r >> $urandom_range(12, 1);
        end
        return r;
    endfunction

    function automatic logic [23:0] rand_degree();
        logic [31:0] d;
        d = $urandom;
        case ($urandom_range(2))
            0:       d[31:4] = '0;
            1:       d[31:8] = '0;
            default: ;
        endcase
        return d[23:0];
    endfunction

    task automatic send_word(input pprk_pkg::t_item w);
        if (gaps_on) begin
            while ($urandom_range(99) < 25) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start  <= 1'b1;
        item_w <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_word(w);
    endtask

    // Holds the sender off until every expected word has come and the block has gone quiet.
    task automatic settle();
        int n;
        start <= 1'b0;
        @(posedge i_clk);
        for (n = 0; n < 4000 && (board.pending_ranks.size() != 0 || busy); n++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write, then read back through the same port.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.set_register(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value) begin
            board.report_mismatch("register readback", value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_traffic(input int words);
        int              sent;
        int              edges;
        int              k;
        int              pick;
        pprk_pkg::t_item w;
        sent = 0;
        while (sent < words) begin
            w    = random_item();
            pick = $urandom_range(99);
            if (pick < 15 || board.loaded_ids.size() == 0) begin
                w.op = pprk_pkg::OP_WRITE;
                if ($urandom_range(1) == 0) begin
                    w.vertex_index[15:6] = '0;
                end
                w.rank_value = rand_rank();
                w.out_degree = rand_degree();
                send_word(w);
                sent++;
            end else if (pick < 80) begin
                // One destination's in-edges; below 22 the run stops short of its last edge,
                // and the partial sum then either runs on or is dropped by an empty destination.
                edges = $urandom_range(6, 1);
                for (k = 0; k < edges; k++) begin
                    w = random_item();
                    w.op = pprk_pkg::OP_EDGE;
                    w.vertex_index =
                        board.loaded_ids[$urandom_range(board.loaded_ids.size() - 1)];
                    w.last = (k == edges - 1) && (pick >= 22);
                    send_word(w);
                    sent++;
                end
                if (pick < 22 && $urandom_range(1) == 0) begin
                    w = random_item();
                    w.op = pprk_pkg::OP_EMPTY;
                    send_word(w);
                    sent++;
                end
            end else if (pick < 92) begin
                w.op = pprk_pkg::OP_EMPTY;
                send_word(w);
                sent++;
            end else begin
                w.op = OP_UNUSED;
                send_word(w);
            end
            if ($urandom_range(199) == 0) begin
                settle();
            end
        end
    endtask

    initial begin
        logic [31:0] tele_set [0:4];
        logic [31:0] damp_set [0:4];
        int          p;

        board = new();
        tele_set[0] = $urandom;      damp_set[0] = pprk_pkg::DAMPING_RESET;
        tele_set[1] = 32'h0;         damp_set[1] = 32'h0;
        tele_set[2] = 32'd2147483;   damp_set[2] = 32'h8000_0000;
        tele_set[3] = $urandom;      damp_set[3] = $urandom_range(32'h8000_0000);
        tele_set[4] = $urandom;      damp_set[4] = 32'hFFFF_FFFF;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers still at their reset values here.
        send_word(word(pprk_pkg::OP_WRITE, 16'h0000, 32'h0000_0000, 24'h00_0000, 1'b0));
        send_word(word(pprk_pkg::OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1));
        send_word(word(pprk_pkg::OP_WRITE, 16'h0001, 32'hFFFF_FFFF, 24'h00_0000, 1'b0));
        send_word(word(pprk_pkg::OP_WRITE, 16'h0002, 32'h8000_0000, 24'h00_0003, 1'b0));
        send_word(word(pprk_pkg::OP_EDGE, 16'h0000, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1));
        send_word(word(pprk_pkg::OP_EDGE, 16'hFFFF, 32'h0, 24'h0, 1'b1));
        send_word(word(pprk_pkg::OP_EDGE, 16'h0001, 32'h0, 24'h0, 1'b0));
        send_word(word(pprk_pkg::OP_EDGE, 16'h0002, 32'h0, 24'h0, 1'b0));
        send_word(word(pprk_pkg::OP_EDGE, 16'h0001, 32'h0, 24'h0, 1'b1));
        send_word(word(pprk_pkg::OP_EMPTY, 16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1));
        send_word(word(pprk_pkg::OP_EDGE, 16'h0001, 32'h0, 24'h0, 1'b0));
        send_word(word(pprk_pkg::OP_EMPTY, 16'h0000, 32'h0, 24'h0, 1'b0));
        send_word(word(OP_UNUSED, 16'h0001, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1));
        send_word(word(pprk_pkg::OP_EDGE, 16'h0002, 32'h0, 24'h0, 1'b1));
        settle();

        // Full teleport with unity damping drives the final clip.
        write_reg(pprk_pkg::REG_TELEPORT, 32'hFFFF_FFFF);
        write_reg(pprk_pkg::REG_DAMPING, 32'h8000_0000);
        send_word(word(pprk_pkg::OP_EDGE, 16'hFFFF, 32'h0, 24'h0, 1'b1));
        send_word(word(pprk_pkg::OP_EMPTY, 16'h1234, 32'h0, 24'h0, 1'b1));
        send_word(word(pprk_pkg::OP_EDGE, 16'h0000, 32'h0, 24'h0, 1'b1));
        send_word(word(pprk_pkg::OP_EDGE, 16'h0001, 32'h0, 24'h0, 1'b0));
        send_word(word(pprk_pkg::OP_EDGE, 16'h0001, 32'h0, 24'h0, 1'b1));
        settle();

        for (p = 0; p < 5; p++) begin
            write_reg(pprk_pkg::REG_TELEPORT, tele_set[p]);
            write_reg(pprk_pkg::REG_DAMPING, damp_set[p]);
            gaps_on = (p != 2);
            run_traffic(300);
            settle();
        end
        gaps_on = 1'b1;

        // A last stretch of traffic back at the default damping.
        write_reg(pprk_pkg::REG_TELEPORT, $urandom);
        write_reg(pprk_pkg::REG_DAMPING, pprk_pkg::DAMPING_RESET);
        run_traffic(100);
        settle();

        if (board.pending_ranks.size() != 0) begin
            board.report_mismatch("results never seen, count", 32'h0,
                                  board.pending_ranks.size());
        end
        if (board.errors == 0) begin
            $display("pagerank_pull_accumulate_top verification clean");
        end else begin
            $display("pagerank_pull_accumulate_top verification failed");
        end
        $finish;
    end

    initial begin
        #12ms;
        $display("pagerank_pull_accumulate_top verification failed");
        $finish;
    end

endmodule
